// ===== rtl/vna_pkg.sv =====
// package for the vertex normal accumulator: sequencer states, opcodes,
// stream field layout and default sizes
// no dependencies
package vna_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EDGE,
    ST_ESHIFT,
    ST_CROSS,
    ST_XMAG,
    ST_XSHIFT,
    ST_NSQ,
    ST_NROOT,
    ST_NDIV,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_GRP,
    ST_RD_LOAD,
    ST_OUT
  } state_t;

  localparam logic [2:0] OP_WRITE_VTX = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_ADD_TRI   = 3'd2;
  localparam logic [2:0] OP_ADD_QUAD  = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 32;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 64;
  localparam int OP_W       = 3;

  // input tdata layout
  localparam int IN_SLOT_LO  = 0;
  localparam int IN_PX_LO    = 10;
  localparam int IN_PY_LO    = 42;
  localparam int IN_PZ_LO    = 74;
  localparam int IN_GRP_LO   = 106;
  localparam int IN_CA_LO    = 116;
  localparam int IN_CB_LO    = 126;
  localparam int IN_CC_LO    = 136;
  localparam int IN_CD_LO    = 146;

  // output tdata layout
  localparam int OUT_SLOT_LO = 0;
  localparam int OUT_NX_LO   = 10;
  localparam int OUT_NY_LO   = 26;
  localparam int OUT_NZ_LO   = 42;

  localparam int EDGE_LIM    = 30;
  localparam int CROSS_LIM   = 31;
  localparam int FRAC_BITS   = 14;
  localparam int QUOT_BITS   = 16;
  localparam int ROOT_STEPS  = 32;
  localparam int CROSS_STEPS = 6;
  localparam logic [15:0] Q_ONE = 16'd16384;

endpackage

// ===== rtl/vertex_normal_accumulator_unit.sv =====
// vertex normal accumulator: vertex table, group accumulators, face normal
// and normalisation sequencer around one shared multiplier
// depends on vna_pkg
//
// throughput: one item at a time; the 32-step square root and three restoring
// divisions of the normaliser set the pace.
// reset: synchronous, active low; after reset the accumulator memory is swept
// to zero with in_tready low.
module vertex_normal_accumulator_unit #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // vertex_slot, pos_x, pos_y, pos_z, normal_group, corner_a..corner_d, zero pad
  input  logic [vna_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [vna_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // read_slot, normal_x, normal_y, normal_z, zero pad
  output logic [vna_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int PW = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int EW = PW + 1;
  localparam int VW = 3 * PW + AW;

  vna_pkg::state_t state_r, state_nxt;

  // memories
  logic [VW-1:0] vmem [MAX_VERTICES];
  logic [95:0]   amem [MAX_VERTICES];
  logic [VW-1:0] vrd_q;
  logic [95:0]   ard_q;
  logic          vwe, awe;
  logic [AW-1:0] vwa, vra, awa, ara;
  logic [VW-1:0] vwd;
  logic [95:0]   awd;

  logic [5:0]    cnt_r;
  logic [1:0]    comp_r;
  logic [AW-1:0] clr_addr_r;
  logic          quad_r, face_r;
  logic [9:0]    slot_r;
  logic [AW-1:0] corner_r [4];
  logic [AW-1:0] g_r [4];
  logic signed [PW-1:0] pos_r [3][3];
  logic [EW-1:0] emag_r [6];
  logic          esgn_r [6];
  logic signed [63:0] x_r [3];
  logic [63:0]   xmag_r [3];
  logic          xsgn_r [3];
  logic [31:0]   nmag_r [3];
  logic          nsgn_r [3];
  logic [63:0]   sum_r, rs_r, root_r, rbit_r;
  logic [31:0]   m_r, rem_r;
  logic [46:0]   num_r;
  logic [15:0]   quot_r;
  logic signed [15:0] q_r [3];
  logic signed [63:0] prod_r;
  logic          out_tvalid_r;
  logic [9:0]    out_slot_r;
  logic [15:0]   out_n_r [3];

  logic          in_acc;
  logic [2:0]    op;
  logic [5:0]    ncorn;
  logic [1:0]    ci;
  logic [EW-1:0] emor;
  logic [63:0]   xmor;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [63:0]   sum_nxt;
  logic [64:0]   rtrial;
  logic          rge;
  logic [63:0]   root_step, rs_step;
  logic [32:0]   dtrial;
  logic          dge;
  logic [15:0]   quot_fin;
  logic [46:0]   num_init;
  logic [5:0]    bidx;
  logic [95:0]   acc_sum;

  function automatic logic [AW-1:0] vidx(input logic [9:0] v);
    return AW'(32'(v) % MAX_VERTICES);
  endfunction

  function automatic logic signed [32:0] sval(input logic s, input logic [EW-1:0] m);
    logic signed [32:0] v;
    v = $signed(33'(m));
    return s ? -v : v;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic signed [15:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) + 33'(b);
    if (s > 33'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (s < -33'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  assign in_acc = in_tvalid && in_tready;
  assign op     = in_tuser;
  assign ncorn  = quad_r ? 6'd4 : 6'd3;
  assign ci     = cnt_r[1:0] - 2'd1;

  always_comb begin
    emor = '0;
    for (int i = 0; i < 6; i++) begin
      emor = emor | emag_r[i];
    end
    xmor = xmag_r[0] | xmag_r[1] | xmag_r[2];
  end

  // shared multiplier, cross terms then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == vna_pkg::ST_CROSS) begin
      unique case (cnt_r)
        6'd0:    begin mul_a = sval(esgn_r[1], emag_r[1]); mul_b = sval(esgn_r[5], emag_r[5]); end
        6'd1:    begin mul_a = sval(esgn_r[2], emag_r[2]); mul_b = sval(esgn_r[4], emag_r[4]); end
        6'd2:    begin mul_a = sval(esgn_r[2], emag_r[2]); mul_b = sval(esgn_r[3], emag_r[3]); end
        6'd3:    begin mul_a = sval(esgn_r[0], emag_r[0]); mul_b = sval(esgn_r[5], emag_r[5]); end
        6'd4:    begin mul_a = sval(esgn_r[0], emag_r[0]); mul_b = sval(esgn_r[4], emag_r[4]); end
        6'd5:    begin mul_a = sval(esgn_r[1], emag_r[1]); mul_b = sval(esgn_r[3], emag_r[3]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == vna_pkg::ST_NSQ && cnt_r < 6'd3) begin
      mul_a = $signed(33'(nmag_r[cnt_r[1:0]]));
      mul_b = $signed(33'(nmag_r[cnt_r[1:0]]));
    end
  end
  assign mul_p = mul_a * mul_b;

  assign sum_nxt   = sum_r + ((cnt_r != 6'd0) ? prod_r : 64'd0);
  assign rtrial    = {1'b0, root_r} + {1'b0, rbit_r};
  assign rge       = {1'b0, rs_r} >= rtrial;
  assign root_step = rge ? (root_r >> 1) + rbit_r : (root_r >> 1);
  assign rs_step   = rge ? rs_r - rtrial[63:0] : rs_r;

  assign bidx     = 6'(vna_pkg::QUOT_BITS) - cnt_r;
  assign dtrial   = {rem_r, num_r[bidx]};
  assign dge      = dtrial >= {1'b0, m_r};
  assign quot_fin = {quot_r[14:0], dge};
  assign num_init = (47'(nmag_r[comp_r]) << vna_pkg::FRAC_BITS) + 47'(m_r >> 1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_sum[32*i +: 32] = sat_add(ard_q[32*i +: 32], q_r[i]);
    end
  end

  // sequencer and memory control
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    vwe = in_acc && (op == vna_pkg::OP_WRITE_VTX);
    vwa = vidx(in_tdata[vna_pkg::IN_SLOT_LO +: 10]);
    vwd = {vidx(in_tdata[vna_pkg::IN_GRP_LO +: 10]),
           PW'(in_tdata[vna_pkg::IN_PZ_LO +: 32]),
           PW'(in_tdata[vna_pkg::IN_PY_LO +: 32]),
           PW'(in_tdata[vna_pkg::IN_PX_LO +: 32])};
    vra = corner_r[cnt_r[1:0]];
    awe = 1'b0;
    awa = g_r[cnt_r[1:0]];
    awd = acc_sum;
    ara = g_r[cnt_r[1:0]];
    unique case (state_r)
      vna_pkg::ST_CLEAR: begin
        awe = 1'b1;
        awa = clr_addr_r;
        awd = '0;
        if (clr_addr_r == AW'(MAX_VERTICES - 1)) begin
          state_nxt = vna_pkg::ST_IDLE;
        end
      end
      vna_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        vra = vidx(in_tdata[vna_pkg::IN_SLOT_LO +: 10]);
        if (in_tvalid) begin
          priority case (op)
            vna_pkg::OP_CLEAR:    state_nxt = vna_pkg::ST_CLEAR;
            vna_pkg::OP_ADD_TRI,
            vna_pkg::OP_ADD_QUAD: state_nxt = vna_pkg::ST_FETCH;
            vna_pkg::OP_READ:     state_nxt = vna_pkg::ST_RD_GRP;
            default:              state_nxt = vna_pkg::ST_IDLE;
          endcase
        end
      end
      vna_pkg::ST_FETCH: begin
        if (cnt_r == ncorn) state_nxt = vna_pkg::ST_EDGE;
      end
      vna_pkg::ST_EDGE: state_nxt = vna_pkg::ST_ESHIFT;
      vna_pkg::ST_ESHIFT: begin
        if ((emor >> vna_pkg::EDGE_LIM) == '0) state_nxt = vna_pkg::ST_CROSS;
      end
      vna_pkg::ST_CROSS: begin
        if (cnt_r == 6'(vna_pkg::CROSS_STEPS)) state_nxt = vna_pkg::ST_XMAG;
      end
      vna_pkg::ST_XMAG: state_nxt = vna_pkg::ST_XSHIFT;
      vna_pkg::ST_XSHIFT: begin
        if ((xmor >> vna_pkg::CROSS_LIM) == '0) state_nxt = vna_pkg::ST_NSQ;
      end
      vna_pkg::ST_NSQ: begin
        if (cnt_r == 6'd3) begin
          if (sum_nxt == '0) begin
            state_nxt = face_r ? vna_pkg::ST_ACC_RD : vna_pkg::ST_OUT;
          end else begin
            state_nxt = vna_pkg::ST_NROOT;
          end
        end
      end
      vna_pkg::ST_NROOT: begin
        if (cnt_r == 6'(vna_pkg::ROOT_STEPS - 1)) state_nxt = vna_pkg::ST_NDIV;
      end
      vna_pkg::ST_NDIV: begin
        if (cnt_r == 6'(vna_pkg::QUOT_BITS) && comp_r == 2'd2) begin
          state_nxt = face_r ? vna_pkg::ST_ACC_RD : vna_pkg::ST_OUT;
        end
      end
      vna_pkg::ST_ACC_RD: state_nxt = vna_pkg::ST_ACC_WR;
      vna_pkg::ST_ACC_WR: begin
        awe = 1'b1;
        state_nxt = (cnt_r + 6'd1 == ncorn) ? vna_pkg::ST_IDLE : vna_pkg::ST_ACC_RD;
      end
      vna_pkg::ST_RD_GRP: begin
        ara = vrd_q[VW-1 -: AW];
        state_nxt = vna_pkg::ST_RD_LOAD;
      end
      vna_pkg::ST_RD_LOAD: state_nxt = vna_pkg::ST_NSQ;
      vna_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) state_nxt = vna_pkg::ST_IDLE;
      end
      default: state_nxt = vna_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwa] <= vwd;
    end
    vrd_q <= vmem[vra];
  end

  always_ff @(posedge clk) begin
    if (awe) begin
      amem[awa] <= awd;
    end
    ard_q <= amem[ara];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vna_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      comp_r       <= '0;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == vna_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end else begin
        clr_addr_r <= '0;
      end
      if (state_r == vna_pkg::ST_ACC_WR) begin
        cnt_r <= cnt_r + 6'd1;
      end else if (state_r == vna_pkg::ST_ACC_RD) begin
        cnt_r <= cnt_r;
      end else if (state_r == vna_pkg::ST_NDIV && cnt_r == 6'(vna_pkg::QUOT_BITS)) begin
        cnt_r  <= '0;
        comp_r <= comp_r + 2'd1;
      end else if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (state_r == vna_pkg::ST_NROOT) begin
        comp_r <= '0;
      end
      if (state_r == vna_pkg::ST_OUT && !out_tvalid_r) begin
        out_tvalid_r <= 1'b1;
      end else if (state_r == vna_pkg::ST_OUT && out_tready) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_p[63:0];
    unique case (state_r)
      vna_pkg::ST_IDLE: begin
        slot_r      <= in_tdata[vna_pkg::IN_SLOT_LO +: 10];
        quad_r      <= (op == vna_pkg::OP_ADD_QUAD);
        corner_r[0] <= vidx(in_tdata[vna_pkg::IN_CA_LO +: 10]);
        corner_r[1] <= vidx(in_tdata[vna_pkg::IN_CB_LO +: 10]);
        corner_r[2] <= vidx(in_tdata[vna_pkg::IN_CC_LO +: 10]);
        corner_r[3] <= vidx(in_tdata[vna_pkg::IN_CD_LO +: 10]);
      end
      vna_pkg::ST_FETCH: begin
        if (cnt_r != 6'd0) begin
          g_r[ci] <= vrd_q[VW-1 -: AW];
          for (int k = 0; k < 3; k++) begin
            if (ci == 2'd0) pos_r[0][k] <= vrd_q[PW*k +: PW];
            if (ci == 2'd1) pos_r[1][k] <= vrd_q[PW*k +: PW];
            // a quad takes the far end of its other edge from corner_d, not corner_c
            if ((ci == 2'd2 && !quad_r) || ci == 2'd3) pos_r[2][k] <= vrd_q[PW*k +: PW];
          end
        end
      end
      vna_pkg::ST_EDGE: begin
        for (int e = 0; e < 2; e++) begin
          for (int k = 0; k < 3; k++) begin
            logic signed [EW-1:0] d;
            d = EW'(pos_r[e+1][k]) - EW'(pos_r[0][k]);
            esgn_r[3*e+k] <= d[EW-1];
            emag_r[3*e+k] <= d[EW-1] ? EW'(-d) : EW'(d);
          end
        end
      end
      vna_pkg::ST_ESHIFT: begin
        if ((emor >> vna_pkg::EDGE_LIM) != '0) begin
          for (int i = 0; i < 6; i++) emag_r[i] <= emag_r[i] >> 1;
        end
      end
      vna_pkg::ST_CROSS: begin
        if (cnt_r != 6'd0) begin
          if (cnt_r[0]) begin
            x_r[2'((cnt_r - 6'd1) >> 1)] <= prod_r;
          end else begin
            x_r[2'((cnt_r - 6'd1) >> 1)] <= x_r[2'((cnt_r - 6'd1) >> 1)] - prod_r;
          end
        end
      end
      vna_pkg::ST_XMAG: begin
        for (int i = 0; i < 3; i++) begin
          xsgn_r[i] <= x_r[i][63];
          xmag_r[i] <= x_r[i][63] ? 64'(-x_r[i]) : 64'(x_r[i]);
        end
      end
      vna_pkg::ST_XSHIFT: begin
        face_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          xmag_r[i] <= xmag_r[i] >> 1;
          nmag_r[i] <= xmag_r[i][31:0];
          nsgn_r[i] <= xsgn_r[i];
        end
        sum_r <= '0;
      end
      vna_pkg::ST_RD_LOAD: begin
        face_r <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          nsgn_r[i] <= ard_q[32*i+31];
          nmag_r[i] <= ard_q[32*i+31] ? 32'(-ard_q[32*i +: 32]) : ard_q[32*i +: 32];
        end
        sum_r <= '0;
      end
      vna_pkg::ST_NSQ: begin
        sum_r  <= sum_nxt;
        rs_r   <= sum_nxt;
        root_r <= '0;
        rbit_r <= 64'd1 << 62;
        if (cnt_r == 6'd3 && sum_nxt == '0) begin
          for (int i = 0; i < 3; i++) q_r[i] <= '0;
        end
      end
      vna_pkg::ST_NROOT: begin
        rs_r   <= rs_step;
        root_r <= root_step;
        rbit_r <= rbit_r >> 2;
        m_r    <= root_step[31:0];
      end
      vna_pkg::ST_NDIV: begin
        if (cnt_r == 6'd0) begin
          num_r  <= num_init;
          rem_r  <= 32'(num_init >> vna_pkg::QUOT_BITS);
          quot_r <= '0;
        end else begin
          rem_r  <= dge ? 32'(dtrial - {1'b0, m_r}) : dtrial[31:0];
          quot_r <= quot_fin;
          if (cnt_r == 6'(vna_pkg::QUOT_BITS)) begin
            q_r[comp_r] <= nsgn_r[comp_r] ? -$signed(quot_fin) : $signed(quot_fin);
          end
        end
      end
      vna_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_slot_r <= slot_r;
          for (int i = 0; i < 3; i++) out_n_r[i] <= q_r[i];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_n_r[2], out_n_r[1], out_n_r[0], out_slot_r};

  // divider remainder must stay below the root
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vna_pkg::ST_NDIV && cnt_r != 6'd0) |-> (rem_r < m_r))
    else $error("divider remainder not below root");

  // a unit normal component never exceeds one in Q2.14
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vna_pkg::ST_NDIV && cnt_r == 6'(vna_pkg::QUOT_BITS))
      |-> (quot_fin <= vna_pkg::Q_ONE))
    else $error("normal component above one");

  // read-modify-write: every ST_ACC_WR write directly follows its ST_ACC_RD read
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vna_pkg::ST_ACC_WR) |-> ($past(state_r) == vna_pkg::ST_ACC_RD))
    else $error("accumulator write without preceding read");

  // a finished result waits while the output register is still full
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vna_pkg::ST_OUT && out_tvalid_r && !out_tready)
      |=> (state_r == vna_pkg::ST_OUT))
    else $error("result overwrote pending output");

endmodule
